@@ rtl/range_grid_to_point_cloud_macros.svh @@
// Assertion macros shared by the range grid to point cloud RTL.
`ifndef RANGE_GRID_TO_POINT_CLOUD_MACROS_SVH
`define RANGE_GRID_TO_POINT_CLOUD_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RGPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RGPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RGPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RGPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/rgpc_pkg.sv @@
// Widths, codes and helper functions of the range grid to point cloud block.
`timescale 1ns / 1ps
package rgpc_pkg;
    localparam int IDX_W        = 10;
    localparam int CNT_W        = 11;
    localparam int RNG_W        = 20;
    localparam int INT_W        = 16;
    localparam int ANG_W        = 16;
    localparam int TRIG_W       = 16;
    localparam int PT_W         = 21;
    localparam int FR_W         = 16;
    localparam int WT_W         = FR_W + 1;
    localparam int NUM_W        = 20;
    localparam int DVD_W        = NUM_W + FR_W;
    localparam int MA_W         = 38;
    localparam int MB_W         = 18;
    localparam int MP_W         = MA_W + MB_W;
    localparam int CX_W         = 34;
    localparam int CZ_W         = 26;
    localparam int STEP_W       = 4;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 20;

    localparam logic signed [CX_W-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_CONVERT = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_H_OUT_COUNT = 3'd0,
        CFG_V_OUT_COUNT = 3'd1,
        CFG_MIN_RANGE   = 3'd2,
        CFG_FAR_CUTOFF  = 3'd3,
        CFG_YAW_MIN     = 3'd4,
        CFG_YAW_STEP    = 3'd5,
        CFG_PITCH_MIN   = 3'd6,
        CFG_PITCH_STEP  = 3'd7
    } t_cfg_index;

    // Arctangent of 2^-i in units of 2^24 per turn.
    function automatic logic signed [CZ_W-1:0] atan_turn24(input logic [STEP_W-1:0] i);
        logic signed [CZ_W-1:0] v;
        unique case (i)
            4'd0:  v = 26'sd2097152;
            4'd1:  v = 26'sd1238021;
            4'd2:  v = 26'sd654136;
            4'd3:  v = 26'sd332050;
            4'd4:  v = 26'sd166669;
            4'd5:  v = 26'sd83416;
            4'd6:  v = 26'sd41718;
            4'd7:  v = 26'sd20860;
            4'd8:  v = 26'sd10430;
            4'd9:  v = 26'sd5215;
            4'd10: v = 26'sd2608;
            4'd11: v = 26'sd1304;
            4'd12: v = 26'sd652;
            4'd13: v = 26'sd326;
            4'd14: v = 26'sd163;
            4'd15: v = 26'sd81;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [TRIG_W-1:0] sat_trig(input logic signed [CX_W-1:0] v);
        logic signed [TRIG_W-1:0] r;
        if (v > 34'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -34'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[TRIG_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [PT_W-1:0] sat_point(input logic signed [MP_W-1:0] v);
        logic signed [PT_W-1:0] r;
        if (v > 56'sd1048575) begin
            r = 21'sh0FFFFF;
        end else if (v < -56'sd1048576) begin
            r = 21'sh100000;
        end else begin
            r = v[PT_W-1:0];
        end
        return r;
    endfunction
endpackage

@@ rtl/rgpc_div.sv @@
// Bit-serial restoring divider that maps an output cell onto the ray grid.
`timescale 1ns / 1ps
module rgpc_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [rgpc_pkg::DVD_W-1:0]    i_dividend,
    input  logic [rgpc_pkg::CNT_W-1:0]    i_divisor,
    output logic                          o_done,
    output logic [rgpc_pkg::DVD_W-1:0]    o_quotient
);
    import rgpc_pkg::*;

    localparam int BIT_W = $clog2(DVD_W + 1);

    typedef enum logic {D_IDLE, D_RUN} t_dstate;

    t_dstate            r_state;
    logic [BIT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_rem;
    logic [CNT_W-1:0]   r_den;
    logic [DVD_W-1:0]   r_quo;
    logic               r_done;

    logic [CNT_W:0]     trial;
    logic               qbit;
    logic [CNT_W:0]     diff;

    // One quotient bit per cycle: shift in the next dividend bit, then
    // subtract the divisor if it fits.
    always_comb begin
        trial = {r_rem, r_quo[DVD_W-1]};
        qbit  = (trial >= {1'b0, r_den});
        diff  = trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_quo   <= i_dividend;
                        r_den   <= i_divisor;
                        r_rem   <= '0;
                        r_count <= '0;
                        r_state <= D_RUN;
                    end
                end
                D_RUN: begin
                    r_rem   <= qbit ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
                    r_quo   <= {r_quo[DVD_W-2:0], qbit};
                    r_count <= r_count + 1'b1;
                    if (r_count == BIT_W'(DVD_W - 1)) begin
                        r_done  <= 1'b1;
                        r_state <= D_IDLE;
                    end
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

@@ rtl/rgpc_cordic.sv @@
// Iterative CORDIC that turns a 16-bit angle into Q1.15 cosine and sine.
`timescale 1ns / 1ps
module rgpc_cordic (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic [rgpc_pkg::ANG_W-1:0]           i_angle,
    output logic                                 o_done,
    output logic signed [rgpc_pkg::TRIG_W-1:0]   o_cos,
    output logic signed [rgpc_pkg::TRIG_W-1:0]   o_sin
);
    import rgpc_pkg::*;

    typedef enum logic [1:0] {C_IDLE, C_RUN, C_FIN} t_cstate;

    t_cstate                    r_state;
    logic signed [CX_W-1:0]     r_x;
    logic signed [CX_W-1:0]     r_y;
    logic signed [CZ_W-1:0]     r_z;
    logic                       r_flip;
    logic [STEP_W-1:0]          r_i;
    logic                       r_done;
    logic signed [TRIG_W-1:0]   r_cos;
    logic signed [TRIG_W-1:0]   r_sin;

    logic signed [ANG_W-1:0]    angle_s;
    logic                       fold;
    logic [ANG_W-1:0]           folded;
    logic signed [CX_W-1:0]     dx;
    logic signed [CX_W-1:0]     dy;
    logic signed [CZ_W-1:0]     atan;
    logic signed [CX_W-1:0]     xf;
    logic signed [CX_W-1:0]     yf;

    // Angles outside a quarter turn either side are moved by half a turn,
    // and the results are negated at the end.
    always_comb begin
        angle_s = signed'(i_angle);
        fold    = (angle_s >= 16'sd16384) || (angle_s < -16'sd16384);
        folded  = fold ? {~i_angle[ANG_W-1], i_angle[ANG_W-2:0]} : i_angle;
        dx      = r_y >>> r_i;
        dy      = r_x >>> r_i;
        atan    = atan_turn24(r_i);
        xf      = r_flip ? -r_x : r_x;
        yf      = r_flip ? -r_y : r_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                C_IDLE: begin
                    if (i_start) begin
                        r_x     <= CORDIC_GAIN;
                        r_y     <= '0;
                        r_z     <= {{(CZ_W-ANG_W-8){folded[ANG_W-1]}}, folded, 8'b0};
                        r_flip  <= fold;
                        r_i     <= '0;
                        r_state <= C_RUN;
                    end
                end
                C_RUN: begin
                    if (!r_z[CZ_W-1]) begin
                        r_x <= r_x - dx;
                        r_y <= r_y + dy;
                        r_z <= r_z - atan;
                    end else begin
                        r_x <= r_x + dx;
                        r_y <= r_y - dy;
                        r_z <= r_z + atan;
                    end
                    r_i <= r_i + 1'b1;
                    if (r_i == {STEP_W{1'b1}}) begin
                        r_state <= C_FIN;
                    end
                end
                C_FIN: begin
                    r_cos   <= sat_trig((xf + 34'sd16384) >>> 15);
                    r_sin   <= sat_trig((yf + 34'sd16384) >>> 15);
                    r_done  <= 1'b1;
                    r_state <= C_IDLE;
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_cos;
    assign o_sin  = r_sin;
endmodule

@@ rtl/range_grid_to_point_cloud.sv @@
// Top level: ray grid store, sequencer and shared multiplier of the point converter.
// A load item is written in the cycle it is accepted and never raises busy.
// A convert item runs two 36-step bit-serial divisions, the corner reads from memory,
// eight multiply steps, two CORDIC runs and four more steps; a point outside the range
// window ends after the multiply steps. busy stays high throughout.
// A result strobe lasts one cycle and the receiver cannot stall it.
// Synchronous active-low reset restores the register defaults; the grid store is not cleared.
`timescale 1ns / 1ps
`include "range_grid_to_point_cloud_macros.svh"
module range_grid_to_point_cloud #(
    parameter int H_RAYS = 64,
    parameter int V_RAYS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  i_command,
    input  logic [rgpc_pkg::IDX_W-1:0]            i_ray_index,
    input  logic [rgpc_pkg::RNG_W-1:0]            i_ray_range,
    input  logic [rgpc_pkg::INT_W-1:0]            i_ray_intensity,
    input  logic [rgpc_pkg::IDX_W-1:0]            i_out_column,
    input  logic [rgpc_pkg::IDX_W-1:0]            i_out_row,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [rgpc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [rgpc_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    output logic                                  o_result_valid,
    output logic signed [rgpc_pkg::PT_W-1:0]      o_point_x,
    output logic signed [rgpc_pkg::PT_W-1:0]      o_point_y,
    output logic signed [rgpc_pkg::PT_W-1:0]      o_point_z,
    output logic [rgpc_pkg::INT_W-1:0]            o_point_intensity,
    output logic [rgpc_pkg::IDX_W-1:0]            o_result_column,
    output logic [rgpc_pkg::IDX_W-1:0]            o_result_row
);
    import rgpc_pkg::*;

    localparam int DEPTH = 1 << IDX_W;
    localparam logic [NUM_W-1:0] HM1 = NUM_W'(H_RAYS - 1);
    localparam logic [NUM_W-1:0] VM1 = NUM_W'(V_RAYS - 1);
    localparam logic [NUM_W-1:0] HN  = NUM_W'(H_RAYS);

    typedef enum logic [2:0] {
        S_IDLE, S_DIVH, S_DIVV, S_READ, S_MAC, S_TRY, S_TRP, S_XYZ
    } t_state;

    // Grid store: one write port for loads, one registered read port.
    logic [RNG_W-1:0] mem_rng [DEPTH];
    logic [INT_W-1:0] mem_int [DEPTH];
    logic [RNG_W-1:0] r_rd_rng;
    logic [INT_W-1:0] r_rd_int;

    // Configuration registers.
    logic [CNT_W-1:0]        r_hcnt;
    logic [CNT_W-1:0]        r_vcnt;
    logic [RNG_W-1:0]        r_min;
    logic [RNG_W-1:0]        r_far;
    logic [ANG_W-1:0]        r_yaw_min;
    logic signed [ANG_W-1:0] r_yaw_step;
    logic [ANG_W-1:0]        r_pitch_min;
    logic signed [ANG_W-1:0] r_pitch_step;

    // Sequencer and datapath registers.
    t_state                  r_state;
    logic [2:0]              r_step;
    logic [IDX_W-1:0]        r_col;
    logic [IDX_W-1:0]        r_row;
    logic [IDX_W-1:0]        r_ha;
    logic [IDX_W-1:0]        r_hb;
    logic [FR_W-1:0]         r_fh;
    logic [IDX_W-1:0]        r_va;
    logic [IDX_W-1:0]        r_vb;
    logic [FR_W-1:0]         r_fv;
    logic [RNG_W-1:0]        r_corner [4];
    logic [INT_W+1:0]        r_isum;
    logic signed [MP_W-1:0]  r_acc;
    logic signed [MA_W-1:0]  r_top;
    logic signed [MA_W-1:0]  r_bot;
    logic [RNG_W-1:0]        r_r;
    logic [ANG_W-1:0]        r_yaw;
    logic [ANG_W-1:0]        r_pitch;
    logic signed [TRIG_W-1:0] r_cy;
    logic signed [TRIG_W-1:0] r_sy;
    logic signed [TRIG_W-1:0] r_cp;
    logic signed [TRIG_W-1:0] r_sp;
    logic signed [MA_W-1:0]  r_tmp;
    logic                    r_valid;
    logic signed [PT_W-1:0]  r_px;
    logic signed [PT_W-1:0]  r_py;
    logic signed [PT_W-1:0]  r_pz;
    logic [INT_W-1:0]        r_pint;
    logic [IDX_W-1:0]        r_res_col;
    logic [IDX_W-1:0]        r_res_row;

    logic                    accept;
    logic                    load_we;

    // Divider hookup.
    logic                    div_start;
    logic [IDX_W-1:0]        div_n;
    logic [NUM_W-1:0]        div_num;
    logic [CNT_W-1:0]        div_den;
    logic                    div_done;
    logic [DVD_W-1:0]        div_quo;

    // Axis mapping of the divider result.
    logic [CNT_W-1:0]        map_cnt;
    logic [NUM_W-1:0]        map_rm1;
    logic [NUM_W-1:0]        map_a;
    logic [FR_W-1:0]         map_f;
    logic [IDX_W-1:0]        map_lo;
    logic [IDX_W-1:0]        map_hi;
    logic [FR_W-1:0]         map_fr;

    // CORDIC hookup.
    logic                    cor_start;
    logic [ANG_W-1:0]        cor_angle;
    logic                    cor_done;
    logic signed [TRIG_W-1:0] cor_cos;
    logic signed [TRIG_W-1:0] cor_sin;

    // Read address of the current corner.
    logic [IDX_W-1:0]        rd_h;
    logic [IDX_W-1:0]        rd_v;
    logic [IDX_W-1:0]        rd_addr;

    // The one multiplier shared by interpolation, angles and coordinates.
    logic signed [MA_W-1:0]  mul_a;
    logic signed [MB_W-1:0]  mul_b;
    logic signed [MP_W-1:0]  mul_p;
    logic signed [MP_W-1:0]  acc_sum;
    logic [WT_W-1:0]         wh;
    logic [WT_W-1:0]         wv;
    logic [CNT_W-1:0]        sum_h;
    logic [CNT_W-1:0]        sum_v;
    logic                    out_of_range;

    assign accept      = start && !busy;
    assign load_we     = accept && (i_command == CMD_LOAD);
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (load_we) begin
            mem_rng[i_ray_index] <= i_ray_range;
            mem_int[i_ray_index] <= i_ray_intensity;
        end
        r_rd_rng <= mem_rng[rd_addr];
        r_rd_int <= mem_int[rd_addr];
    end

    // The column division starts straight from the accepted item; the row
    // division follows once the column result is taken.
    always_comb begin
        div_start = 1'b0;
        div_n     = r_row;
        div_den   = r_vcnt - 1'b1;
        div_num   = NUM_W'(r_row) * VM1;
        if (r_state == S_IDLE) begin
            div_start = accept && (i_command == CMD_CONVERT);
            div_n     = i_out_column;
            div_den   = r_hcnt - 1'b1;
            div_num   = NUM_W'(div_n) * HM1;
        end else if (r_state == S_DIVH) begin
            div_start = div_done;
        end
    end

    rgpc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({div_num, {FR_W{1'b0}}}),
        .i_divisor  (div_den),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Lower ray, clamped upper neighbor and fraction. A count below two maps
    // everything to ray zero; a lower ray at or past the last ray pins both corners.
    always_comb begin
        map_cnt = (r_state == S_DIVH) ? r_hcnt : r_vcnt;
        map_rm1 = (r_state == S_DIVH) ? HM1 : VM1;
        map_a   = div_quo[DVD_W-1:FR_W];
        map_f   = div_quo[FR_W-1:0];
        if (map_cnt < CNT_W'(2)) begin
            map_a = '0;
            map_f = '0;
        end
        if (map_a >= map_rm1) begin
            map_lo = map_rm1[IDX_W-1:0];
            map_hi = map_rm1[IDX_W-1:0];
            map_fr = '0;
        end else begin
            map_lo = map_a[IDX_W-1:0];
            map_hi = map_a[IDX_W-1:0] + 1'b1;
            map_fr = map_f;
        end
    end

    // Corners in the order upper-left, upper-right, lower-left, lower-right.
    always_comb begin
        rd_h    = r_step[0] ? r_hb : r_ha;
        rd_v    = r_step[1] ? r_vb : r_va;
        rd_addr = IDX_W'({{(NUM_W-IDX_W){1'b0}}, rd_h} +
                         {{(NUM_W-IDX_W){1'b0}}, rd_v} * HN);
    end

    always_comb begin
        cor_start = 1'b0;
        cor_angle = r_pitch;
        if (r_state == S_MAC && r_step == 3'd7) begin
            cor_start = !out_of_range;
            cor_angle = r_yaw;
        end else if (r_state == S_TRY) begin
            cor_start = cor_done;
        end
    end

    rgpc_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_angle (cor_angle),
        .o_done  (cor_done),
        .o_cos   (cor_cos),
        .o_sin   (cor_sin)
    );

    // Operand selection for the shared multiplier.
    always_comb begin
        wh    = WT_W'(1 << FR_W) - {1'b0, r_fh};
        wv    = WT_W'(1 << FR_W) - {1'b0, r_fv};
        sum_h = {1'b0, r_ha} + {1'b0, r_hb};
        sum_v = {1'b0, r_va} + {1'b0, r_vb};
        mul_a = '0;
        mul_b = '0;
        if (r_state == S_MAC) begin
            unique case (r_step)
                3'd0: begin
                    mul_a = {{(MA_W-RNG_W){1'b0}}, r_corner[0]};
                    mul_b = {1'b0, wh};
                end
                3'd1: begin
                    mul_a = {{(MA_W-RNG_W){1'b0}}, r_corner[1]};
                    mul_b = {2'b0, r_fh};
                end
                3'd2: begin
                    mul_a = {{(MA_W-RNG_W){1'b0}}, r_corner[2]};
                    mul_b = {1'b0, wh};
                end
                3'd3: begin
                    mul_a = {{(MA_W-RNG_W){1'b0}}, r_corner[3]};
                    mul_b = {2'b0, r_fh};
                end
                3'd4: begin
                    mul_a = r_top;
                    mul_b = {1'b0, wv};
                end
                3'd5: begin
                    mul_a = r_bot;
                    mul_b = {2'b0, r_fv};
                end
                3'd6: begin
                    mul_a = {{(MA_W-CNT_W){1'b0}}, sum_h};
                    mul_b = {{(MB_W-ANG_W){r_yaw_step[ANG_W-1]}}, r_yaw_step};
                end
                3'd7: begin
                    mul_a = {{(MA_W-CNT_W){1'b0}}, sum_v};
                    mul_b = {{(MB_W-ANG_W){r_pitch_step[ANG_W-1]}}, r_pitch_step};
                end
                default: ;
            endcase
        end else if (r_state == S_XYZ) begin
            unique case (r_step[1:0])
                2'd0: begin
                    mul_a = {{(MA_W-RNG_W){1'b0}}, r_r};
                    mul_b = {{(MB_W-TRIG_W){r_cp[TRIG_W-1]}}, r_cp};
                end
                2'd1: begin
                    mul_a = r_tmp;
                    mul_b = {{(MB_W-TRIG_W){r_cy[TRIG_W-1]}}, r_cy};
                end
                2'd2: begin
                    mul_a = r_tmp;
                    mul_b = {{(MB_W-TRIG_W){r_sy[TRIG_W-1]}}, r_sy};
                end
                2'd3: begin
                    mul_a = {{(MA_W-RNG_W){1'b0}}, r_r};
                    mul_b = {{(MB_W-TRIG_W){r_sp[TRIG_W-1]}}, r_sp};
                end
                default: ;
            endcase
        end
        mul_p        = mul_a * mul_b;
        acc_sum      = r_acc + mul_p;
        out_of_range = (r_r < r_min) || (r_r > r_far);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_step       <= '0;
            r_valid      <= 1'b0;
            r_hcnt       <= CNT_W'(64);
            r_vcnt       <= CNT_W'(16);
            r_min        <= '0;
            r_far        <= {RNG_W{1'b1}};
            r_yaw_min    <= '0;
            r_yaw_step   <= '0;
            r_pitch_min  <= '0;
            r_pitch_step <= '0;
        end else begin
            r_valid <= 1'b0;

            if (i_cfg_valid && o_cfg_ready) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_H_OUT_COUNT: r_hcnt       <= i_cfg_data[CNT_W-1:0];
                    CFG_V_OUT_COUNT: r_vcnt       <= i_cfg_data[CNT_W-1:0];
                    CFG_MIN_RANGE:   r_min        <= i_cfg_data[RNG_W-1:0];
                    CFG_FAR_CUTOFF:  r_far        <= i_cfg_data[RNG_W-1:0];
                    CFG_YAW_MIN:     r_yaw_min    <= i_cfg_data[ANG_W-1:0];
                    CFG_YAW_STEP:    r_yaw_step   <= signed'(i_cfg_data[ANG_W-1:0]);
                    CFG_PITCH_MIN:   r_pitch_min  <= i_cfg_data[ANG_W-1:0];
                    CFG_PITCH_STEP:  r_pitch_step <= signed'(i_cfg_data[ANG_W-1:0]);
                    default: ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept && (i_command == CMD_CONVERT)) begin
                        r_col   <= i_out_column;
                        r_row   <= i_out_row;
                        r_state <= S_DIVH;
                    end
                end
                S_DIVH: begin
                    if (div_done) begin
                        r_ha    <= map_lo;
                        r_hb    <= map_hi;
                        r_fh    <= map_fr;
                        r_state <= S_DIVV;
                    end
                end
                S_DIVV: begin
                    if (div_done) begin
                        r_va    <= map_lo;
                        r_vb    <= map_hi;
                        r_fv    <= map_fr;
                        r_isum  <= '0;
                        r_step  <= '0;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    // Read data arrives in the cycle after its address.
                    if (r_step != 3'd0) begin
                        r_corner[r_step[1:0] - 2'd1] <= r_rd_rng;
                        r_isum <= r_isum + {2'b0, r_rd_int};
                    end
                    if (r_step == 3'd4) begin
                        r_step  <= '0;
                        r_state <= S_MAC;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_MAC: begin
                    r_step <= r_step + 1'b1;
                    unique case (r_step)
                        3'd0: r_acc <= mul_p;
                        3'd1: r_top <= acc_sum[MA_W-1:0];
                        3'd2: r_acc <= mul_p;
                        3'd3: r_bot <= acc_sum[MA_W-1:0];
                        3'd4: r_acc <= mul_p;
                        3'd5: r_r   <= acc_sum[32 +: RNG_W];
                        3'd6: r_yaw <= r_yaw_min + mul_p[ANG_W:1];
                        3'd7: begin
                            r_pitch <= r_pitch_min + mul_p[ANG_W:1];
                            // Points outside the range window are dropped here.
                            r_state <= out_of_range ? S_IDLE : S_TRY;
                        end
                        default: ;
                    endcase
                end
                S_TRY: begin
                    if (cor_done) begin
                        r_cy    <= cor_cos;
                        r_sy    <= cor_sin;
                        r_state <= S_TRP;
                    end
                end
                S_TRP: begin
                    if (cor_done) begin
                        r_cp    <= cor_cos;
                        r_sp    <= cor_sin;
                        r_step  <= '0;
                        r_state <= S_XYZ;
                    end
                end
                S_XYZ: begin
                    r_step <= r_step + 1'b1;
                    unique case (r_step[1:0])
                        2'd0: r_tmp <= mul_p[MA_W-1:0];
                        2'd1: r_px  <= sat_point((mul_p + (56'sd1 <<< 29)) >>> 30);
                        2'd2: r_py  <= sat_point((mul_p + (56'sd1 <<< 29)) >>> 30);
                        2'd3: begin
                            r_pz      <= sat_point((mul_p + 56'sd16384) >>> 15);
                            r_pint    <= r_isum[INT_W+1:2];
                            r_res_col <= r_col;
                            r_res_row <= r_row;
                            r_valid   <= 1'b1;
                            r_state   <= S_IDLE;
                        end
                        default: ;
                    endcase
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_result_valid    = r_valid;
    assign o_point_x         = r_px;
    assign o_point_y         = r_py;
    assign o_point_z         = r_pz;
    assign o_point_intensity = r_pint;
    assign o_result_column   = r_res_col;
    assign o_result_row      = r_res_row;

    `RGPC_ASSERT_NXT(a_convert_busy, i_clk, i_rst_n, accept && (i_command == CMD_CONVERT), busy)
    `RGPC_ASSERT_NXT(a_load_idle, i_clk, i_rst_n, accept && (i_command == CMD_LOAD), !busy)
    `RGPC_ASSERT_IMP(a_strobe_idle, i_clk, i_rst_n, o_result_valid, !busy)
    `RGPC_ASSERT_NXT(a_strobe_single, i_clk, i_rst_n, o_result_valid, !o_result_valid)
endmodule

@@ tb/tb_range_grid_to_point_cloud.sv @@
// Self-checking testbench of the range grid to point cloud converter.
`timescale 1ns / 1ps
module tb_range_grid_to_point_cloud;
    import rgpc_pkg::*;

    // The largest run is well under this; it leaves room many times over.
    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE_CYCLES = 300;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 100;

    typedef struct packed {
        logic signed [PT_W-1:0] x;
        logic signed [PT_W-1:0] y;
        logic signed [PT_W-1:0] z;
        logic [INT_W-1:0]       inten;
        logic [IDX_W-1:0]       col;
        logic [IDX_W-1:0]       row;
    } t_point;

    typedef struct {
        logic             cmd;
        logic [IDX_W-1:0] idx;
        logic [RNG_W-1:0] rng;
        logic [INT_W-1:0] inten;
        logic [IDX_W-1:0] col;
        logic [IDX_W-1:0] row;
        bit               typed;
        t_point           pt;
    } t_stim_row;

    localparam longint ATAN_TURN24 [16] = '{
        2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
        10430, 5215, 2608, 1304, 652, 326, 163, 81
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic                  i_command;
    logic [IDX_W-1:0]      i_ray_index;
    logic [RNG_W-1:0]      i_ray_range;
    logic [INT_W-1:0]      i_ray_intensity;
    logic [IDX_W-1:0]      i_out_column;
    logic [IDX_W-1:0]      i_out_row;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  o_result_valid;
    logic signed [PT_W-1:0] o_point_x;
    logic signed [PT_W-1:0] o_point_y;
    logic signed [PT_W-1:0] o_point_z;
    logic [INT_W-1:0]      o_point_intensity;
    logic [IDX_W-1:0]      o_result_column;
    logic [IDX_W-1:0]      o_result_row;

    range_grid_to_point_cloud dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_command(i_command), .i_ray_index(i_ray_index), .i_ray_range(i_ray_range),
        .i_ray_intensity(i_ray_intensity), .i_out_column(i_out_column),
        .i_out_row(i_out_row), .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_result_valid(o_result_valid), .o_point_x(o_point_x), .o_point_y(o_point_y),
        .o_point_z(o_point_z), .o_point_intensity(o_point_intensity),
        .o_result_column(o_result_column), .o_result_row(o_result_row)
    );

    // Shadow copy of the grid and of the register file.
    logic [RNG_W-1:0] range_mem [1024];
    logic [INT_W-1:0] inten_mem [1024];
    logic [CNT_W-1:0] h_count, v_count;
    logic [RNG_W-1:0] min_rng, far_rng;
    logic [ANG_W-1:0] yaw_base, yaw_inc, pitch_base, pitch_inc;

    t_point pending_points [$];
    int     mismatches;
    int     cycles;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Maps one output cell onto the ray grid: lower ray, clamped upper neighbour and fraction.
    function automatic void map_cell(input logic [IDX_W-1:0] n, input logic [CNT_W-1:0] count,
                                     input int rays, output int lo, output int hi,
                                     output longint frac);
        int unsigned num, den, a;
        longint f;
        a = 0;
        f = 0;
        if (count > 1) begin
            num = n * (rays - 1);
            den = count - 1;
            a = num / den;
            f = (longint'(num % den) << 16) / den;
        end
        if (a >= rays - 1) begin
            lo = rays - 1;
            hi = rays - 1;
            frac = 0;
        end else begin
            lo = a;
            hi = a + 1;
            frac = f;
        end
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic void cordic_trig(input logic [ANG_W-1:0] ang, output longint c,
                                        output longint s);
        longint a, x, y, z, dx, dy;
        logic [ANG_W-1:0] folded;
        bit flip;
        a = longint'($signed(ang));
        flip = 1'b0;
        if (a >= 16384 || a < -16384) begin
            // Fold by a half turn and negate the outcome.
            folded = ang ^ 16'h8000;
            a = longint'($signed(folded));
            flip = 1'b1;
        end
        x = 652032874;
        y = 0;
        z = a * 256;
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - ATAN_TURN24[i];
            end else begin
                x = x + dx; y = y - dy; z = z + ATAN_TURN24[i];
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = clamp((x + 16384) >>> 15, -32768, 32767);
        s = clamp((y + 16384) >>> 15, -32768, 32767);
    endfunction

    function automatic logic [ANG_W-1:0] ray_angle(input logic [ANG_W-1:0] base, input int sum,
                                                   input logic [ANG_W-1:0] step);
        longint p;
        p = longint'(sum) * longint'($signed(step));
        return ANG_W'(longint'($signed(base)) + (p >>> 1));
    endfunction

    function automatic bit project_cell(input logic [IDX_W-1:0] col, input logic [IDX_W-1:0] row,
                                        output t_point pt);
        int ha, hb, va, vb;
        longint fh, fv, top, bot, r, cy, sy, cp, sp;
        int j1, j2, j3, j4;
        map_cell(col, h_count, 64, ha, hb, fh);
        map_cell(row, v_count, 16, va, vb, fv);
        j1 = (ha + va * 64) % 1024;
        j2 = (hb + va * 64) % 1024;
        j3 = (ha + vb * 64) % 1024;
        j4 = (hb + vb * 64) % 1024;
        top = longint'(range_mem[j1]) * (65536 - fh) + longint'(range_mem[j2]) * fh;
        bot = longint'(range_mem[j3]) * (65536 - fh) + longint'(range_mem[j4]) * fh;
        r = (top * (65536 - fv) + bot * fv) >> 32;
        pt = '0;
        if (r < min_rng || r > far_rng) return 1'b0;
        pt.inten = INT_W'((int'(inten_mem[j1]) + inten_mem[j2] + inten_mem[j3]
                          + inten_mem[j4]) >> 2);
        cordic_trig(ray_angle(yaw_base, ha + hb, yaw_inc), cy, sy);
        cordic_trig(ray_angle(pitch_base, va + vb, pitch_inc), cp, sp);
        pt.x = PT_W'(clamp((r * cp * cy + (64'sd1 << 29)) >>> 30, -1048576, 1048575));
        pt.y = PT_W'(clamp((r * cp * sy + (64'sd1 << 29)) >>> 30, -1048576, 1048575));
        pt.z = PT_W'(clamp((r * sp + 16384) >>> 15, -1048576, 1048575));
        pt.col = col;
        pt.row = row;
        return 1'b1;
    endfunction

    // Issue one item; it is taken at the first rising edge with busy low.
    task automatic issue_item(input t_stim_row item, input int gap);
        t_point pt;
        @(negedge i_clk);
        start           <= 1'b1;
        i_command       <= item.cmd;
        i_ray_index     <= item.idx;
        i_ray_range     <= item.rng;
        i_ray_intensity <= item.inten;
        i_out_column    <= item.col;
        i_out_row       <= item.row;
        do @(posedge i_clk); while (busy);
        if (item.cmd == CMD_LOAD) begin
            range_mem[item.idx] = item.rng;
            inten_mem[item.idx] = item.inten;
        end else if (project_cell(item.col, item.row, pt)) begin
            pending_points.push_back(item.typed ? item.pt : pt);
        end
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_H_OUT_COUNT: h_count    = data[CNT_W-1:0];
            CFG_V_OUT_COUNT: v_count    = data[CNT_W-1:0];
            CFG_MIN_RANGE:   min_rng    = data;
            CFG_FAR_CUTOFF:  far_rng    = data;
            CFG_YAW_MIN:     yaw_base   = data[ANG_W-1:0];
            CFG_YAW_STEP:    yaw_inc    = data[ANG_W-1:0];
            CFG_PITCH_MIN:   pitch_base = data[ANG_W-1:0];
            default:         pitch_inc  = data[ANG_W-1:0];
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Let every point arrive, then give a dropped convert time to finish.
    task automatic drain_block();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_stim_row load_row(input int idx, input int rng, input int inten);
        t_stim_row row;
        row = '{default: '0};
        row.cmd = CMD_LOAD;
        row.idx = IDX_W'(idx);
        row.rng = RNG_W'(rng);
        row.inten = INT_W'(inten);
        return row;
    endfunction

    function automatic t_stim_row conv_row(input int col, input int row_n, input bit typed,
                                           input int inten);
        t_stim_row row;
        row = '{default: '0};
        row.cmd = CMD_CONVERT;
        row.col = IDX_W'(col);
        row.row = IDX_W'(row_n);
        row.typed = typed;
        row.pt.inten = INT_W'(inten);
        row.pt.col = IDX_W'(col);
        row.pt.row = IDX_W'(row_n);
        return row;
    endfunction

    // Result checker: each strobe is matched against the oldest pending point.
    always @(posedge i_clk) begin
        t_point got, want;
        if (i_rst_n && o_result_valid) begin
            got = '{o_point_x, o_point_y, o_point_z, o_point_intensity,
                    o_result_column, o_result_row};
            if (pending_points.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected point %p", got);
            end else begin
                want = pending_points.pop_front();
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= 10) $display("point mismatch: expected %p got %p", want, got);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_range_grid_to_point_cloud: FAIL");
            $finish;
        end
    end

    initial begin
        t_stim_row directed [$];
        t_stim_row item;
        int gap_max;
        logic [CFG_DATA_W-1:0] cfg [8];

        mismatches = 0;
        cycles = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_command = CMD_LOAD;
        i_ray_index = '0;
        i_ray_range = '0;
        i_ray_intensity = '0;
        i_out_column = '0;
        i_out_row = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_H_OUT_COUNT;
        i_cfg_data = '0;
        h_count = 11'd64;
        v_count = 11'd16;
        min_rng = '0;
        far_rng = 20'hFFFFF;
        yaw_base = '0;
        yaw_inc = '0;
        pitch_base = '0;
        pitch_inc = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Fill the whole grid so that no convert ever reads an unwritten entry.
        for (int k = 0; k < 1024; k++) issue_item(load_row(k, 0, 0), 0);

        // Directed part under the reset register values.
        // Zero ranges give a point at the origin; the intensity is the corner average.
        foreach (directed[k]) directed.delete(k);
        directed.push_back(load_row(0, 0, 100));
        directed.push_back(load_row(1, 0, 100));
        directed.push_back(load_row(64, 0, 100));
        directed.push_back(load_row(65, 0, 100));
        directed.push_back(conv_row(0, 0, 1'b1, 100));
        directed.push_back(load_row(0, 0, 65535));
        directed.push_back(load_row(1, 0, 65535));
        directed.push_back(load_row(64, 0, 65535));
        directed.push_back(load_row(65, 0, 65535));
        directed.push_back(conv_row(0, 0, 1'b1, 65535));
        // Full scale ranges near the far corner, then cells past the grid edges.
        directed.push_back(load_row(1023, 1048575, 65535));
        directed.push_back(load_row(1022, 1048575, 65535));
        directed.push_back(load_row(959, 1048575, 0));
        directed.push_back(load_row(958, 1048575, 65535));
        directed.push_back(conv_row(1023, 1023, 1'b0, 0));
        directed.push_back(conv_row(63, 15, 1'b0, 0));
        directed.push_back(conv_row(62, 14, 1'b0, 0));
        directed.push_back(conv_row(1023, 0, 1'b0, 0));
        directed.push_back(conv_row(0, 1023, 1'b0, 0));
        directed.push_back(load_row(512, 1048575, 0));
        directed.push_back(conv_row(0, 8, 1'b0, 0));
        directed.push_back(conv_row(31, 7, 1'b0, 0));
        foreach (directed[k]) issue_item(directed[k], $urandom_range(0, 3));

        for (int p = 0; p < PHASES; p++) begin
            // The sender holds off here until every pending point has come.
            drain_block();
            for (int r = 0; r < 8; r++) cfg[r] = CFG_DATA_W'($urandom);
            case (p)
                0: begin
                    cfg[0][CNT_W-1:0] = 11'd1;
                    cfg[1][CNT_W-1:0] = 11'd1;
                    cfg[2] = '0;
                    cfg[3] = 20'hFFFFF;
                    cfg[4][15:0] = 16'h8000;
                    cfg[5][15:0] = 16'h7FFF;
                    cfg[6][15:0] = 16'h7FFF;
                    cfg[7][15:0] = 16'h8000;
                end
                1: begin
                    cfg[0][CNT_W-1:0] = 11'd1024;
                    cfg[1][CNT_W-1:0] = 11'd1024;
                    cfg[2] = '0;
                    cfg[3] = 20'hFFFFF;
                    cfg[4][15:0] = 16'h7FFF;
                    cfg[5][15:0] = 16'h8000;
                    cfg[6][15:0] = 16'h8000;
                    cfg[7][15:0] = 16'h0000;
                end
                2: begin
                    cfg[0][CNT_W-1:0] = 11'd2;
                    cfg[1][CNT_W-1:0] = 11'd2;
                    cfg[2] = 20'hFFFFF;
                    cfg[3] = 20'hFFFFF;
                end
                3: begin
                    // A narrow window drops most points.
                    cfg[0][CNT_W-1:0] = CNT_W'($urandom_range(1, 1024));
                    cfg[1][CNT_W-1:0] = CNT_W'($urandom_range(1, 1024));
                    cfg[2] = 20'h40000;
                    cfg[3] = 20'hC0000;
                end
                default: begin
                    cfg[0][CNT_W-1:0] = CNT_W'($urandom_range(1, 1024));
                    cfg[1][CNT_W-1:0] = CNT_W'($urandom_range(1, 64));
                    cfg[2] = RNG_W'($urandom_range(0, 20'h3FFFF));
                    cfg[3] = RNG_W'($urandom_range(20'h80000, 20'hFFFFF));
                end
            endcase
            for (int r = 0; r < 8; r++) write_reg(t_cfg_index'(r), cfg[r]);

            gap_max = (p % 3 == 1) ? 0 : 19;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(0, 99) < 35) begin
                    item = load_row($urandom_range(0, 1023), $urandom_range(0, 20'hFFFFF),
                                    $urandom_range(0, 65535));
                end else if ($urandom_range(0, 9) < 8) begin
                    item = conv_row($urandom_range(0, h_count - 1),
                                    $urandom_range(0, v_count - 1), 1'b0, 0);
                end else begin
                    item = conv_row($urandom_range(0, 1023), $urandom_range(0, 1023), 1'b0, 0);
                end
                issue_item(item, $urandom_range(0, gap_max));
            end
        end

        drain_block();
        if (mismatches == 0 && pending_points.size() == 0) begin
            $display("tb_range_grid_to_point_cloud: PASS");
        end else begin
            $display("tb_range_grid_to_point_cloud: FAIL");
        end
        $finish;
    end
endmodule
